/* rtl/core/ptta_pkg.sv */
// ----------------------------------------------------------------------------
// ptta_pkg
// Shared types and constants for the page table translate and allocate block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptta_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned PID_W   = 16;
  localparam int unsigned PAGE_W  = 26;
  localparam int unsigned FRAME_W = 26;
  localparam int unsigned SIZE_W  = 27;
  localparam int unsigned ADDR_W  = 26;
  localparam int unsigned PHYS_W  = 52;
  localparam int unsigned CHG_W   = 7;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [SIZE_W-1:0] PAGE_SIZE_RESET = 27'd4096;
  // Highest legal end of an add request, in bytes.
  localparam logic [28:0]       MEM_LIMIT       = 29'd67108864;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_TERM  = 2'd2,
    OP_TRANS = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_EXCEED    = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SEARCH,
    S_INSERT,
    S_MUL,
    S_SUM,
    S_DONE
  } state_e;

  // One table entry as it travels around the ring.
  typedef struct packed {
    logic               valid;
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/ptta_cell.sv */
// ----------------------------------------------------------------------------
// ptta_cell
// One table slot; it passes its entry to the next cell on every clock.
// ----------------------------------------------------------------------------
`default_nettype none

module ptta_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ptta_pkg::entry_t d_i,
  output ptta_pkg::entry_t     q_o
);
  import ptta_pkg::*;

  logic                         valid_q;
  logic [PID_W+PAGE_W+FRAME_W-1:0] payload_q;

  // The valid bit is cleared by reset so the table starts empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= d_i.valid;
    end
  end

  // Key and frame need no reset; they are read only when valid.
  always_ff @(posedge clk_i) begin
    payload_q <= {d_i.pid, d_i.page, d_i.frame};
  end

  assign q_o = {valid_q, payload_q};

endmodule

`default_nettype wire

/* rtl/core/ptta_div.sv */
// ----------------------------------------------------------------------------
// ptta_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ptta_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ptta_pkg::SIZE_W-1:0]  dividend_i,
  input  wire logic [ptta_pkg::SIZE_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [ptta_pkg::SIZE_W-1:0]       quotient_o,
  output logic [ptta_pkg::SIZE_W-1:0]       remainder_o
);
  import ptta_pkg::*;

  localparam int unsigned CNT_W = $clog2(SIZE_W);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SIZE_W-1:0] rem_q, quo_q, dsr_q;
  logic [SIZE_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_q, quo_q[SIZE_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(SIZE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? SIZE_W'(trial - {1'b0, dsr_q}) : trial[SIZE_W-1:0];
      quo_q <= {quo_q[SIZE_W-2:0], fits};
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* rtl/core/page_table_translate_alloc.sv */
// ----------------------------------------------------------------------------
// page_table_translate_alloc
// Page table kept as a rotating ring of entry cells, with add, delete,
// terminate and translate operations.
// ----------------------------------------------------------------------------
// Every table scan is one full turn of the ring of TABLE_ENTRIES cells. A
// delete makes one scan; a translate divides, scans, multiplies and sums;
// terminate scans once per page removed and once more; an add divides, then
// scans per page and inserts each new page; an out of range add ends at once.
// Throughput: one item at a time; the next item is taken once a result is
// registered. Reset empties the table and sets the page size to 4096.
`default_nettype none

module page_table_translate_alloc #(
  parameter int unsigned TABLE_ENTRIES = ptta_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Page size register.
  input  wire logic                             cfg_we_i,
  input  wire logic [ptta_pkg::SIZE_W-1:0]      cfg_wdata_i,
  // Request items.
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // pid[15:0], start_page[41:16], alloc_size[68:42], vaddr[94:69]
  input  wire logic [ptta_pkg::IN_DATA_W-1:0]   s_tdata,
  // op[1:0]
  input  wire logic [1:0]                       s_tuser,
  // Result items.
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // physical_address[51:0], pages_changed[58:52]
  output logic [ptta_pkg::OUT_DATA_W-1:0]       m_tdata,
  // status[1:0]
  output logic [1:0]                            m_tuser
);
  import ptta_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_ENTRIES);

  // Request fields.
  logic [PID_W-1:0]  in_pid;
  logic [PAGE_W-1:0] in_page;
  logic [SIZE_W-1:0] in_size;
  logic [ADDR_W-1:0] in_va;
  assign in_pid  = s_tdata[15:0];
  assign in_page = s_tdata[41:16];
  assign in_size = s_tdata[68:42];
  assign in_va   = s_tdata[94:69];

  // Page size register; zero acts as one.
  logic [SIZE_W-1:0] page_size_q, ps_eff;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_size_q <= PAGE_SIZE_RESET;
    end else if (cfg_we_i) begin
      page_size_q <= cfg_wdata_i;
    end
  end
  assign ps_eff = (page_size_q == '0) ? SIZE_W'(1) : page_size_q;

  // Ring of cells; the controller sees the last cell and feeds the first.
  entry_t ring [TABLE_ENTRIES];
  entry_t head, wb;
  assign head = ring[TABLE_ENTRIES-1];

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      ptta_cell u_cell (.clk_i, .rst_ni, .d_i(wb), .q_o(ring[i]));
    end else begin : g_rest
      ptta_cell u_cell (.clk_i, .rst_ni, .d_i(ring[i-1]), .q_o(ring[i]));
    end
  end

  // Shared divider for page count and address split.
  logic              div_start, div_done;
  logic [SIZE_W-1:0] div_dividend, div_quo, div_rem;
  ptta_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_dividend), .divisor_i(ps_eff),
    .done_o(div_done), .quotient_o(div_quo), .remainder_o(div_rem)
  );

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [PID_W-1:0]    pid_q, pid_d;
  logic [PAGE_W-1:0]   cur_q, cur_d;
  logic [SIZE_W-1:0]   rem_q, rem_d, off_q, off_d;
  logic [FRAME_W-1:0]  frame_q, frame_d, newf_q, newf_d;
  logic                found_q, found_d, free_q, free_d;
  logic [FRAME_W:0]    maxf_q, maxf_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [52:0]         prod_q, prod_d;
  logic [PHYS_W-1:0]   phys_q, phys_d;
  status_e             status_q, status_d;
  logic [CHG_W-1:0]    chg_q, chg_d;
  logic                m_valid_q, m_valid_d;
  logic [PHYS_W-1:0]   m_phys_q, m_phys_d;
  logic [CHG_W-1:0]    m_chg_q, m_chg_d;
  status_e             m_stat_q, m_stat_d;

  logic              hit, found_n, free_n, pass_end, accept;
  logic [FRAME_W:0]  maxf_n, head_next;
  logic [28:0]       add_end;

  assign s_tready  = (state_q == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign hit       = head.valid && (head.pid == pid_q) && (head.page == cur_q);
  assign found_n   = found_q | hit;
  assign free_n    = free_q | ~head.valid;
  assign head_next = {1'b0, head.frame} + 1'b1;
  assign maxf_n    = (head.valid && (head_next > maxf_q)) ? head_next : maxf_q;
  assign pass_end  = (cnt_q == CW'(TABLE_ENTRIES - 1));
  assign add_end   = 29'(in_page) + 29'(ps_eff) + 29'(in_size);

  // Sequencer: next state, ring write-back and result fields.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    pid_d     = pid_q;
    cur_d     = cur_q;
    rem_d     = rem_q;
    off_d     = off_q;
    frame_d   = frame_q;
    newf_d    = newf_q;
    found_d   = found_q;
    free_d    = free_q;
    maxf_d    = maxf_q;
    cnt_d     = cnt_q;
    prod_d    = prod_q;
    phys_d    = phys_q;
    status_d  = status_q;
    chg_d     = chg_q;
    m_valid_d = m_valid_q && !m_tready;
    m_phys_d  = m_phys_q;
    m_chg_d   = m_chg_q;
    m_stat_d  = m_stat_q;
    wb        = head;
    div_start = 1'b0;
    div_dividend = (op_e'(s_tuser) == OP_ADD) ? in_size : SIZE_W'(in_va);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = op_e'(s_tuser);
          pid_d    = in_pid;
          status_d = STAT_OK;
          phys_d   = '0;
          chg_d    = '0;
          cnt_d    = '0;
          case (op_e'(s_tuser))
            OP_ADD: begin
              cur_d = in_page;
              if (add_end > MEM_LIMIT) begin
                status_d = STAT_EXCEED;
                state_d  = S_DONE;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
            OP_DEL: begin
              cur_d   = in_page;
              state_d = S_SEARCH;
            end
            OP_TERM: begin
              cur_d   = '0;
              state_d = S_SEARCH;
            end
            default: begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          endcase
        end
      end

      S_DIV: begin
        if (div_done) begin
          if (op_q == OP_ADD) begin
            rem_d = div_quo + 1'b1;
          end else begin
            cur_d = div_quo[PAGE_W-1:0];
            off_d = div_rem;
          end
          cnt_d   = '0;
          state_d = S_SEARCH;
        end
      end

      // One full turn of the ring per probed page.
      S_SEARCH: begin
        found_d = found_n;
        free_d  = free_n;
        maxf_d  = maxf_n;
        cnt_d   = cnt_q + 1'b1;
        if (hit) begin
          frame_d = head.frame;
          if (op_q == OP_DEL || op_q == OP_TERM) begin
            wb.valid = 1'b0;
          end
        end
        if (pass_end) begin
          found_d = 1'b0;
          free_d  = 1'b0;
          maxf_d  = '0;
          cnt_d   = '0;
          case (op_q)
            OP_ADD: begin
              if (found_n) begin
                rem_d = rem_q - 1'b1;
                cur_d = cur_q + 1'b1;
                if (rem_q == SIZE_W'(1)) begin
                  state_d = S_DONE;
                end
              end else if (free_n) begin
                newf_d  = maxf_n[FRAME_W-1:0];
                state_d = S_INSERT;
              end else begin
                status_d = STAT_FULL;
                state_d  = S_DONE;
              end
            end
            OP_DEL: begin
              status_d = found_n ? STAT_OK : STAT_NOT_FOUND;
              chg_d    = CHG_W'(found_n);
              state_d  = S_DONE;
            end
            OP_TERM: begin
              if (found_n) begin
                chg_d = chg_q + 1'b1;
                cur_d = cur_q + 1'b1;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              if (found_n) begin
                state_d = S_MUL;
              end else begin
                status_d = STAT_NOT_FOUND;
                state_d  = S_DONE;
              end
            end
          endcase
        end
      end

      // Drop the new page into the first empty slot that comes by.
      S_INSERT: begin
        if (!head.valid) begin
          wb.valid = 1'b1;
          wb.pid   = pid_q;
          wb.page  = cur_q;
          wb.frame = newf_q;
          chg_d    = chg_q + 1'b1;
          rem_d    = rem_q - 1'b1;
          cur_d    = cur_q + 1'b1;
          cnt_d    = '0;
          state_d  = (rem_q == SIZE_W'(1)) ? S_DONE : S_SEARCH;
        end
      end

      S_MUL: begin
        prod_d  = {27'd0, frame_q} * {26'd0, ps_eff};
        state_d = S_SUM;
      end

      S_SUM: begin
        phys_d  = PHYS_W'(prod_q + 53'(off_q));
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!m_valid_q || m_tready) begin
          m_valid_d = 1'b1;
          m_phys_d  = phys_q;
          m_chg_d   = chg_q;
          m_stat_d  = status_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      maxf_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      found_q   <= found_d;
      free_q    <= free_d;
      maxf_q    <= maxf_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pid_q    <= pid_d;
    cur_q    <= cur_d;
    rem_q    <= rem_d;
    off_q    <= off_d;
    frame_q  <= frame_d;
    newf_q   <= newf_d;
    prod_q   <= prod_d;
    phys_q   <= phys_d;
    status_q <= status_d;
    chg_q    <= chg_d;
    m_phys_q <= m_phys_d;
    m_chg_q  <= m_chg_d;
    m_stat_q <= m_stat_d;
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = {5'd0, m_chg_q, m_phys_q};
  assign m_tuser  = m_stat_q;

  // A pending result is never dropped before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result item dropped while stalled");

  // Only an add ever writes a new entry.
  a_insert_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |-> op_q == OP_ADD)
    else $error("insert outside an add");

  // A delete removes at most one entry.
  a_del_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && op_q == OP_DEL) |-> chg_q <= CHG_W'(1))
    else $error("delete changed more than one entry");

  // An accepted item blocks the next one: not ready in the cycle after accept.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_tready)
    else $error("second item taken while busy");

endmodule

`default_nettype wire
